>>> rtl/srrr_pkg.sv
// Package for the selective-repeat reorder receiver.
// Types, codes and constants shared by controller, datapath and top level.
// No dependencies.
package srrr_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_TIMEOUT = 2'd1;

	localparam logic [1:0] RES_ACK       = 2'd0;
	localparam logic [1:0] RES_DELIVER   = 2'd1;
	localparam logic [1:0] RES_COMPLETED = 2'd2;
	localparam logic [1:0] RES_LOST      = 2'd3;

	localparam logic [1:0] REG_SESSION_ID = 2'd0;
	localparam logic [1:0] REG_FILE_SIZE  = 2'd1;
	localparam logic [1:0] REG_MAX_RETRY  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  packet_id;
		logic [31:0] seq;
		logic [15:0] payload_size;
		logic [15:0] payload_tag;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] result_seq;
		logic [15:0] result_size;
		logic [15:0] result_tag;
		logic [6:0]  progress_percent;
		logic        last;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_INSERT,
		ST_DRAIN,
		ST_DIV,
		ST_EMIT_ACK,
		ST_EMIT_DEL,
		ST_EMIT_DONE,
		ST_EMIT_LOST
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_item;    // capture input word, start scan at entry 0
		logic scan_step;    // compare one entry, advance scan index
		logic insert_step;  // shift one entry toward the tail or write item
		logic pop_head;     // deliver head entry and shift buffer down
		logic start_div;    // start progress division
		logic clr_timeout;
		logic inc_timeout;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic found;
		logic below;
		logic full;
		logic insert_done;
		logic head_ready;
		logic complete;
		logic div_busy;
		logic retry_hit;
		logic ignore;
		logic is_timeout;
	} dp_status_t;

endpackage

>>> rtl/srrr_datapath.sv
// Datapath of the selective-repeat reorder receiver: reorder buffer, counters,
// serial scan/insert/pop and the restoring progress divider.
// Depends on srrr_pkg.
module srrr_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srrr_pkg::in_word_t   item,
	input  srrr_pkg::dp_cmd_t    cmd,
	input  logic [7:0]           session_id,
	input  logic [31:0]          file_size,
	input  logic [7:0]           max_retry,
	output srrr_pkg::dp_status_t status,
	output logic [31:0]          item_seq,
	output logic [31:0]          exp_seq,
	output logic [15:0]          del_size,
	output logic [15:0]          del_tag,
	output logic [31:0]          del_seq,
	output logic [6:0]           percent
);
	import srrr_pkg::*;

	// buffer storage, no reset
	logic [31:0] seq_q  [DEPTH];
	logic [15:0] size_q [DEPTH];
	logic [15:0] tag_q  [DEPTH];

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [31:0] expected_q;
	logic [31:0] bytes_q;
	logic [7:0]  timeout_q;
	in_word_t    item_q;
	logic        found_q;
	logic [31:0] del_seq_q;
	logic [15:0] del_size_q;
	logic [15:0] del_tag_q;

	// divider: bytes*100 (39 bits) / file_size, one quotient bit per cycle
	logic [38:0] dividend_q;
	logic [39:0] rem_q;
	logic [6:0]  quot_q;
	logic [5:0]  div_cnt_q;
	logic        div_busy_q;

	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] idx_m1;
	logic             scan_at_end;
	logic             shift_more;
	logic [31:0]      room;
	logic [31:0]      bytes_nxt;
	logic [31:0]      div_src;
	logic [39:0]      rem_sh;
	logic [39:0]      rem_sub;

	assign idx         = idx_q[IDX_W-1:0];
	assign idx_m1      = idx - IDX_W'(1);
	assign scan_at_end = (idx_q == count_q);
	assign shift_more  = (idx_q != '0) && (seq_q[idx_m1] > item_q.seq);
	assign room        = 32'hFFFF_FFFF - bytes_q;
	assign bytes_nxt   = ({16'd0, size_q[0]} > room) ? 32'hFFFF_FFFF
		: bytes_q + {16'd0, size_q[0]};
	// a division started with a pop sees the bytes after that delivery
	assign div_src     = cmd.pop_head ? bytes_nxt : bytes_q;
	assign rem_sh      = {rem_q[38:0], dividend_q[38]};
	assign rem_sub     = rem_sh - {8'd0, file_size};

	// buffer: insert shifts from tail toward the insert point, pop shifts down
	always_ff @(posedge clk) begin
		if (cmd.insert_step) begin
			if (shift_more) begin
				seq_q[idx]  <= seq_q[idx_m1];
				size_q[idx] <= size_q[idx_m1];
				tag_q[idx]  <= tag_q[idx_m1];
			end else begin
				seq_q[idx]  <= item_q.seq;
				size_q[idx] <= item_q.payload_size;
				tag_q[idx]  <= item_q.payload_tag;
			end
		end
		if (cmd.pop_head) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				seq_q[i]  <= seq_q[i+1];
				size_q[i] <= size_q[i+1];
				tag_q[i]  <= tag_q[i+1];
			end
			del_seq_q  <= seq_q[0];
			del_size_q <= size_q[0];
			del_tag_q  <= tag_q[0];
		end
		if (cmd.load_item)
			item_q <= item;
	end

	// control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			idx_q      <= '0;
			expected_q <= '0;
			bytes_q    <= '0;
			timeout_q  <= '0;
			found_q    <= 1'b0;
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
			dividend_q <= '0;
			rem_q      <= '0;
			quot_q     <= '0;
		end else begin
			if (cmd.load_item) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (seq_q[idx] == item_q.seq)
					found_q <= 1'b1;
				idx_q <= idx_q + CNT_W'(1);
			end
			// insert walks idx from count down to the slot
			if (cmd.insert_step) begin
				if (shift_more) begin
					idx_q <= idx_q - CNT_W'(1);
				end else begin
					count_q <= count_q + CNT_W'(1);
					idx_q   <= count_q + CNT_W'(1);
				end
			end
			if (cmd.pop_head) begin
				count_q    <= count_q - CNT_W'(1);
				bytes_q    <= bytes_nxt;
				expected_q <= expected_q + 32'd1;
			end
			if (cmd.clr_timeout)
				timeout_q <= '0;
			else if (cmd.inc_timeout)
				timeout_q <= timeout_q + 8'd1;
			// progress division, quotient saturates at 127
			if (cmd.start_div) begin
				div_busy_q <= (file_size != 32'd0);
				dividend_q <= {1'b0, div_src, 6'd0} + {2'd0, div_src, 5'd0}
					+ {5'd0, div_src, 2'd0};
				rem_q      <= '0;
				quot_q     <= '0;
				div_cnt_q  <= 6'd39;
			end else if (div_busy_q) begin
				dividend_q <= {dividend_q[37:0], 1'b0};
				if (rem_sh >= {8'd0, file_size}) begin
					rem_q  <= rem_sub;
					quot_q <= quot_q[6] ? 7'd127 : {quot_q[5:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					quot_q <= quot_q[6] ? 7'd127 : {quot_q[5:0], 1'b0};
				end
				div_cnt_q <= div_cnt_q - 6'd1;
				if (div_cnt_q == 6'd1)
					div_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status.scan_done   = scan_at_end;
		status.found       = found_q;
		status.below       = expected_q > item_q.seq;
		status.full        = (count_q == CNT_W'(DEPTH));
		status.insert_done = !shift_more;
		status.head_ready  = (count_q != '0) && (seq_q[0] == expected_q);
		status.complete    = (bytes_q == file_size);
		status.div_busy    = div_busy_q;
		status.retry_hit   = ((timeout_q + 8'd1) == max_retry);
		status.ignore      = (item_q.kind == KIND_DATA) ? (item_q.packet_id != session_id)
			: (item_q.kind != KIND_TIMEOUT);
		status.is_timeout  = (item_q.kind == KIND_TIMEOUT);
	end

	assign item_seq = item_q.seq;
	assign exp_seq  = expected_q;
	assign del_size = del_size_q;
	assign del_tag  = del_tag_q;
	assign del_seq  = del_seq_q;
	assign percent  = (file_size == 32'd0) ? 7'd100
		: ((quot_q > 7'd100) ? 7'd100 : quot_q);
endmodule

>>> rtl/srrr_controller.sv
// Controller of the selective-repeat reorder receiver: sequences scan, insert,
// drain, progress division and result emission. Depends on srrr_pkg.
module srrr_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           res_kind,
	output logic                 res_last,
	input  srrr_pkg::dp_status_t status,
	output srrr_pkg::dp_cmd_t    cmd
);
	import srrr_pkg::*;

	state_t state_q, state_d;
	state_t emit_q, emit_d;
	logic   receiving_q, receiving_d;
	logic   dup_q, dup_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			emit_q      <= ST_EMIT_ACK;
			receiving_q <= 1'b1;
			dup_q       <= 1'b0;
		end else begin
			state_q     <= state_d;
			emit_q      <= emit_d;
			receiving_q <= receiving_d;
			dup_q       <= dup_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		emit_d      = emit_q;
		receiving_d = receiving_q;
		dup_d       = dup_q;
		cmd         = '0;
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		res_kind    = RES_ACK;
		res_last    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = receiving_q ? ST_SEARCH : ST_IDLE;
				end
			end
			ST_SEARCH: begin
				if (status.ignore) begin
					state_d = ST_IDLE;
				end else if (status.is_timeout) begin
					if (status.retry_hit) begin
						cmd.clr_timeout = 1'b1;
						receiving_d     = 1'b0;
						cmd.start_div   = 1'b1;
						emit_d          = ST_EMIT_LOST;
						state_d         = ST_DIV;
					end else begin
						cmd.inc_timeout = 1'b1;
						state_d         = ST_IDLE;
					end
				end else if (status.scan_done || status.found) begin
					state_d = ST_DECIDE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_DECIDE: begin
				if (status.found || status.below) begin
					// duplicate: ack again, no delivery
					cmd.clr_timeout = 1'b1;
					cmd.start_div   = 1'b1;
					emit_d          = ST_EMIT_ACK;
					dup_d           = 1'b1;
					state_d         = ST_DIV;
				end else begin
					dup_d   = 1'b0;
					state_d = status.full ? ST_DRAIN : ST_INSERT;
				end
			end
			ST_INSERT: begin
				cmd.insert_step = 1'b1;
				if (status.insert_done) begin
					cmd.clr_timeout = 1'b1;
					cmd.start_div   = 1'b1;
					emit_d          = ST_EMIT_ACK;
					state_d         = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!status.div_busy)
					state_d = emit_q;
			end
			ST_EMIT_ACK: begin
				out_valid = 1'b1;
				res_kind  = RES_ACK;
				res_last  = dup_q || !status.head_ready;
				if (!out_stall)
					state_d = dup_q ? ST_IDLE : ST_DRAIN;
			end
			ST_DRAIN: begin
				if (status.head_ready) begin
					cmd.pop_head    = 1'b1;
					cmd.clr_timeout = 1'b1;
					cmd.start_div   = 1'b1;
					emit_d          = ST_EMIT_DEL;
					state_d         = ST_DIV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_DEL: begin
				out_valid = 1'b1;
				res_kind  = RES_DELIVER;
				res_last  = !status.complete && !status.head_ready;
				if (!out_stall)
					state_d = status.complete ? ST_EMIT_DONE : ST_DRAIN;
			end
			ST_EMIT_DONE: begin
				out_valid = 1'b1;
				res_kind  = RES_COMPLETED;
				res_last  = 1'b1;
				if (!out_stall) begin
					receiving_d = 1'b0;
					state_d     = ST_IDLE;
				end
			end
			ST_EMIT_LOST: begin
				out_valid = 1'b1;
				res_kind  = RES_LOST;
				res_last  = 1'b1;
				if (!out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

>>> rtl/selective_repeat_reorder_receiver_top.sv
// Selective-repeat reorder receiver. One input word is taken at a time and the
// input stalls until its results are out. An ignored word, a foreign packet or a
// timeout that does not end the session is settled in the search state; a word
// after the session ended is dropped as it is taken. A data word is compared
// against the buffered entries one at a time, then decided and, unless it is a
// duplicate or the buffer is full, inserted by moving entries one at a time, followed
// by a serial progress division and its result word; each delivery adds a head
// check, a division and its result word, and any output stall holds the emission.
// Depends on srrr_pkg, srrr_controller and srrr_datapath.
module selective_repeat_reorder_receiver_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  srrr_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output srrr_pkg::out_word_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import srrr_pkg::*;

	logic [7:0]  session_id_q;
	logic [31:0] file_size_q;
	logic [7:0]  max_retry_q;
	dp_cmd_t     cmd;
	dp_status_t  status;
	logic [31:0] item_seq, exp_seq, del_seq;
	logic [15:0] del_size, del_tag;
	logic [6:0]  percent;
	logic [1:0]  res_kind;
	logic        res_last;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_id_q <= 8'd0;
			file_size_q  <= 32'd1;
			max_retry_q  <= 8'd3;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_SESSION_ID: session_id_q <= pwdata[7:0];
				REG_FILE_SIZE:  file_size_q  <= pwdata;
				REG_MAX_RETRY:  max_retry_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SESSION_ID: prdata = {24'd0, session_id_q};
			REG_FILE_SIZE:  prdata = file_size_q;
			REG_MAX_RETRY:  prdata = {24'd0, max_retry_q};
			default:        prdata = 32'd0;
		endcase
	end

	srrr_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_kind  (res_kind),
		.res_last  (res_last),
		.status    (status),
		.cmd       (cmd)
	);

	srrr_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (in_data),
		.cmd        (cmd),
		.session_id (session_id_q),
		.file_size  (file_size_q),
		.max_retry  (max_retry_q),
		.status     (status),
		.item_seq   (item_seq),
		.exp_seq    (exp_seq),
		.del_size   (del_size),
		.del_tag    (del_tag),
		.del_seq    (del_seq),
		.percent    (percent)
	);

	// result word assembly
	always_comb begin
		out_data.result_kind      = res_kind;
		out_data.progress_percent = percent;
		out_data.last             = res_last;
		out_data.result_size      = 16'd0;
		out_data.result_tag       = 16'd0;
		case (res_kind)
			RES_ACK:       out_data.result_seq = item_seq;
			RES_DELIVER: begin
				out_data.result_seq  = del_seq;
				out_data.result_size = del_size;
				out_data.result_tag  = del_tag;
			end
			default:       out_data.result_seq = exp_seq;
		endcase
	end
endmodule

>>> bench/tb.sv
// Testbench for the selective-repeat reorder receiver: random and directed words,
// an in-bench predictor of the receiver, and an APB register writer.
// Depends on srrr_pkg and selective_repeat_reorder_receiver_top.
module tb;
	import srrr_pkg::*;

	localparam logic [1:0] KIND_OTHER = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int LIMIT_CYCLES = 1500000;
	localparam int SETTLE = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	selective_repeat_reorder_receiver_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver shadow state and registers
	logic [31:0] rb_seq [DEPTH];
	logic [15:0] rb_size [DEPTH];
	logic [15:0] rb_tag [DEPTH];
	int unsigned rb_count;
	logic [31:0] next_seq;
	logic [31:0] byte_total;
	logic [7:0] tick_count;
	bit session_open;
	logic [7:0] cfg_session;
	logic [31:0] cfg_file_size;
	logic [7:0] cfg_retry;

	in_word_t pending_words [$];
	out_word_t awaited_results [$];
	int errors = 0;
	int words_taken = 0;
	int in_gap = 0, in_calm = 0, out_gap = 0, out_calm = 0;
	int hold_off = 0;
	bit hold_done = 0;
	longint cycles = 0;

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) calm = $urandom_range(20, 60);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [6:0] percent_done();
		logic [63:0] p;
		if (cfg_file_size == 0) return 7'd100;
		p = (64'(byte_total) * 100) / cfg_file_size;
		return (p > 100) ? 7'd100 : p[6:0];
	endfunction

	function automatic void add_result(logic [1:0] k, logic [31:0] s, logic [15:0] sz,
			logic [15:0] tg);
		out_word_t r;
		r.result_kind = k;
		r.result_seq = s;
		r.result_size = sz;
		r.result_tag = tg;
		r.progress_percent = percent_done();
		r.last = 1'b0;
		awaited_results.push_back(r);
	endfunction

	// advance the shadow receiver by one word, queue what it emits
	function automatic void receive_word(in_word_t w);
		int base_count;
		bit dup;
		int unsigned pos;
		logic [15:0] sz;
		logic [15:0] tg;
		logic [31:0] ds;
		out_word_t tail;
		base_count = awaited_results.size();
		dup = 0;
		if (!session_open) return;
		if (w.kind == KIND_TIMEOUT) begin
			tick_count = tick_count + 8'd1;
			if (tick_count == cfg_retry) begin
				session_open = 0;
				tick_count = '0;
				add_result(RES_LOST, next_seq, '0, '0);
			end
		end else if (w.kind == KIND_DATA && w.packet_id == cfg_session) begin
			for (int i = 0; i < rb_count; i++)
				if (rb_seq[i] == w.seq) dup = 1;
			if (dup || next_seq > w.seq) begin
				tick_count = '0;
				add_result(RES_ACK, w.seq, '0, '0);
			end else begin
				if (rb_count < DEPTH) begin
					pos = 0;
					while (pos < rb_count && rb_seq[pos] <= w.seq) pos++;
					for (int k = rb_count; k > pos; k--) begin
						rb_seq[k] = rb_seq[k-1];
						rb_size[k] = rb_size[k-1];
						rb_tag[k] = rb_tag[k-1];
					end
					rb_seq[pos] = w.seq;
					rb_size[pos] = w.payload_size;
					rb_tag[pos] = w.payload_tag;
					rb_count++;
					tick_count = '0;
					add_result(RES_ACK, w.seq, '0, '0);
				end
				// drain in-order head entries
				while (rb_count > 0 && rb_seq[0] == next_seq) begin
					sz = rb_size[0];
					tg = rb_tag[0];
					ds = rb_seq[0];
					if (32'(sz) > 32'hFFFF_FFFF - byte_total) byte_total = 32'hFFFF_FFFF;
					else byte_total = byte_total + 32'(sz);
					for (int i = 0; i + 1 < rb_count; i++) begin
						rb_seq[i] = rb_seq[i+1];
						rb_size[i] = rb_size[i+1];
						rb_tag[i] = rb_tag[i+1];
					end
					rb_count--;
					next_seq = next_seq + 32'd1;
					tick_count = '0;
					add_result(RES_DELIVER, ds, sz, tg);
					if (byte_total == cfg_file_size) begin
						add_result(RES_COMPLETED, next_seq, '0, '0);
						session_open = 0;
						break;
					end
				end
			end
		end
		if (awaited_results.size() > base_count) begin
			tail = awaited_results.pop_back();
			tail.last = 1'b1;
			awaited_results.push_back(tail);
		end
	endfunction

	// word source: valid held until taken, gaps between words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				receive_word(in_data);
				words_taken++;
				in_gap = pick_gap(in_calm);
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					in_data <= pending_words.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result sink: compare against the oldest awaited result, random stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					if (errors < 10)
						$display("unexpected result kind=%0d seq=%h", out_data.result_kind,
							out_data.result_seq);
					errors++;
				end else begin
					out_word_t e;
					e = awaited_results.pop_front();
					if (out_data.result_kind !== e.result_kind ||
							out_data.result_seq !== e.result_seq ||
							out_data.result_size !== e.result_size ||
							out_data.result_tag !== e.result_tag ||
							out_data.progress_percent !== e.progress_percent ||
							out_data.last !== e.last) begin
						if (errors < 10)
							$display("mismatch exp k=%0d s=%h sz=%h t=%h p=%0d l=%0d got k=%0d s=%h sz=%h t=%h p=%0d l=%0d",
								e.result_kind, e.result_seq, e.result_size, e.result_tag,
								e.progress_percent, e.last, out_data.result_kind,
								out_data.result_seq, out_data.result_size, out_data.result_tag,
								out_data.progress_percent, out_data.last);
						errors++;
					end
				end
			end
			// one long hold-off while the source keeps offering
			if (!hold_done && words_taken >= 90) begin
				hold_done = 1;
				hold_off = 3000;
			end
			if (hold_off > 0) begin
				hold_off--;
				out_stall <= 1'b1;
			end else if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_gap = pick_gap(out_calm);
				out_stall <= 1'b0;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SESSION_ID: cfg_session = val[7:0];
			REG_FILE_SIZE: cfg_file_size = val;
			REG_MAX_RETRY: cfg_retry = val[7:0];
			default: ;
		endcase
	endtask

	task automatic push_word(logic [1:0] k, logic [7:0] id, logic [31:0] s,
			logic [15:0] sz, logic [15:0] tg);
		in_word_t w;
		w.kind = k;
		w.packet_id = id;
		w.seq = s;
		w.payload_size = sz;
		w.payload_tag = tg;
		pending_words.push_back(w);
	endtask

	// wait until all words are taken and every result is in, then let it settle
	task automatic wait_quiet();
		while (pending_words.size() > 0 || in_valid || awaited_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic drain_batch();
		while (pending_words.size() > 0) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_size();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'h0000;
		if (r == 1) return 16'hFFFF;
		return 16'($urandom_range(0, 2000));
	endfunction

	task automatic random_phase(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 6)
				push_word(KIND_TIMEOUT, 8'($urandom), $urandom, 16'($urandom), 16'($urandom));
			else if (r < 8)
				push_word(KIND_OTHER, cfg_session, next_seq, 16'($urandom), 16'($urandom));
			else if (r < 10)
				push_word(KIND_SPARE, cfg_session, next_seq, 16'($urandom), 16'($urandom));
			else if (r < 14)
				push_word(KIND_DATA, cfg_session ^ 8'($urandom_range(1, 255)),
					next_seq + $urandom_range(0, 8), rand_size(), 16'($urandom));
			else if (r < 22)
				push_word(KIND_DATA, cfg_session, next_seq - $urandom_range(1, 4),
					rand_size(), 16'($urandom));
			else if (r < 45)
				push_word(KIND_DATA, cfg_session, next_seq, rand_size(), 16'($urandom));
			else
				push_word(KIND_DATA, cfg_session, next_seq + $urandom_range(1, 20),
					rand_size(), 16'($urandom));
			if (i % 8 == 7) drain_batch();
		end
	endtask

	initial begin
		rb_count = 0;
		next_seq = '0;
		byte_total = '0;
		tick_count = '0;
		session_open = 1;
		cfg_session = 8'd0;
		cfg_file_size = 32'd1;
		cfg_retry = 8'd3;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words
		reg_write(REG_SESSION_ID, 32'hA5);
		reg_write(REG_FILE_SIZE, 32'hFFFF_FFFF);
		reg_write(REG_MAX_RETRY, 32'd255);
		push_word(KIND_DATA, 8'hA5, 32'd0, 16'h0000, 16'h0000);
		push_word(KIND_DATA, 8'hA5, 32'd0, 16'hFFFF, 16'hFFFF);
		push_word(KIND_DATA, 8'hA5, 32'd2, 16'hFFFF, 16'hFFFF);
		push_word(KIND_DATA, 8'hA5, 32'd2, 16'h1234, 16'h5678);
		push_word(KIND_DATA, 8'h5A, 32'd1, 16'h0001, 16'h0001);
		push_word(KIND_OTHER, 8'hA5, 32'd1, 16'h0001, 16'h0001);
		push_word(KIND_SPARE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		push_word(KIND_TIMEOUT, 8'h00, 32'd0, 16'h0000, 16'h0000);
		push_word(KIND_DATA, 8'hA5, 32'd1, 16'h00AA, 16'hAAAA);
		push_word(KIND_DATA, 8'hA5, 32'hFFFF_FFFF, 16'h5555, 16'h5555);
		wait_quiet();
		// fill the buffer out of order, send a duplicate, then the expected word while full
		for (int k = 2; k <= 16; k++)
			push_word(KIND_DATA, 8'hA5, next_seq + k, 16'(k * 100), 16'(k));
		push_word(KIND_DATA, 8'hA5, next_seq + 1, 16'd7, 16'd7);
		push_word(KIND_DATA, 8'hA5, next_seq + 1, 16'd9, 16'd9);
		push_word(KIND_DATA, 8'hA5, next_seq, 16'd3, 16'd3);
		wait_quiet();

		// random phases over several register settings
		reg_write(REG_SESSION_ID, 32'h00);
		reg_write(REG_FILE_SIZE, 32'd0);
		random_phase(40);
		wait_quiet();
		reg_write(REG_SESSION_ID, 32'hFF);
		reg_write(REG_FILE_SIZE, byte_total + 32'd50_000_000);
		reg_write(REG_MAX_RETRY, 32'd0);
		random_phase(50);
		wait_quiet();
		reg_write(REG_SESSION_ID, 32'h5A);
		reg_write(REG_FILE_SIZE, 32'hFFFF_FFFF);
		reg_write(REG_MAX_RETRY, 32'd100);
		random_phase(60);
		wait_quiet();
		reg_write(REG_SESSION_ID, 32'h3C);
		reg_write(REG_FILE_SIZE, byte_total + 32'd2_000_000);
		reg_write(REG_MAX_RETRY, 32'd255);
		random_phase(50);
		wait_quiet();

		// close the session, either by completion or by lost connection
		if ($urandom_range(0, 1)) begin
			reg_write(REG_MAX_RETRY, 32'd1);
			push_word(KIND_DATA, cfg_session, next_seq - 1, 16'd0, 16'd0);
			push_word(KIND_TIMEOUT, cfg_session, 32'd0, 16'd0, 16'd0);
		end else begin
			reg_write(REG_FILE_SIZE, byte_total + 32'd7);
			push_word(KIND_DATA, cfg_session, next_seq, 16'd7, 16'hBEEF);
		end
		push_word(KIND_DATA, cfg_session, next_seq + 1, 16'd1, 16'd1);
		push_word(KIND_TIMEOUT, cfg_session, 32'd0, 16'd0, 16'd0);
		wait_quiet();

		if (awaited_results.size() > 0) errors++;
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/srrr_pkg.sv
rtl/srrr_datapath.sv
rtl/srrr_controller.sv
rtl/selective_repeat_reorder_receiver_top.sv
bench/tb.sv
